FILE: hw/rtl/dcc_rtpb_pkg.sv
// Shared types, constants and packet byte helpers for the DCC refresh packet builder.
// No dependencies.
`default_nettype none
package dcc_rtpb_pkg;
    localparam int Entries = 16;
    localparam int IdxW = $clog2(Entries);
    localparam int CntW = $clog2(Entries + 1);

    typedef enum logic [2:0] {
        OP_CLEAR_ALL = 3'd0,
        OP_CLEAR_ONE = 3'd1,
        OP_UPDATE    = 3'd2,
        OP_STOP_ALL  = 3'd3,
        OP_NEXT      = 3'd4
    } op_t;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_PKT  = 2'd2;

    localparam logic [1:0] KIND_IDLE = 2'd0;
    localparam logic [1:0] KIND_LOCO = 2'd1;
    localparam logic [1:0] KIND_ACC  = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN,
        CMD_APPLY,
        CMD_BUILD
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t code;
        logic      scan_first;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       scan_done;
    } stat_t;

    function automatic logic [7:0] speed_byte(input logic signed [6:0] s);
        logic [7:0] b;
        logic [6:0] mag;
        logic [4:0] m5;
        logic [3:0] h;
        begin
            b = 8'h40;
            if (!s[6])
            begin
                b = b | 8'h20;
                mag = s;
            end
            else
            begin
                mag = 7'(-s);
            end
            m5 = (mag > 7'd31) ? 5'd31 : mag[4:0];
            if (m5[0])
            begin
                b = b | 8'h10;
            end
            h = m5[4:1];
            if (h == 4'd1)
            begin
                h = 4'd2;
            end
            speed_byte = b | {4'd0, h};
        end
    endfunction

    function automatic logic [7:0] function_byte(input logic [12:0] f, input logic [1:0] g);
        begin
            if (g == 2'd1)
            begin
                function_byte = {3'b100, f[0], f[4:1]};
            end
            else if (g == 2'd2)
            begin
                function_byte = {4'hB, f[8:5]};
            end
            else
            begin
                function_byte = {4'hA, f[12:9]};
            end
        end
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/dcc_rtpb_ctrl.sv
// Controller state machine of the DCC refresh packet builder.
// Depends on dcc_rtpb_pkg.
`default_nettype none
module dcc_rtpb_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire dcc_rtpb_pkg::stat_t stat,
    output dcc_rtpb_pkg::cmd_t    cmd
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_BUILD, S_OUT} state_t;
    state_t state_reg, state_next;
    logic   first_reg, first_next;

    always_comb
    begin
        state_next = state_reg;
        first_next = first_reg;
        cmd.code = dcc_rtpb_pkg::CMD_NONE;
        cmd.scan_first = first_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.code = dcc_rtpb_pkg::CMD_LOAD;
                    state_next = S_SCAN;
                    first_next = 1'b1;
                end
            end
            S_SCAN:
            begin
                cmd.code = dcc_rtpb_pkg::CMD_SCAN;
                first_next = 1'b0;
                if (stat.scan_done)
                begin
                    state_next = (stat.op == dcc_rtpb_pkg::OP_NEXT) ? S_BUILD : S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.code = dcc_rtpb_pkg::CMD_APPLY;
                state_next = S_OUT;
            end
            S_BUILD:
            begin
                cmd.code = dcc_rtpb_pkg::CMD_BUILD;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/dcc_rtpb_dp.sv
// Datapath of the DCC refresh packet builder: entry table, scan counter, packet bytes.
// Depends on dcc_rtpb_pkg.
`default_nettype none
module dcc_rtpb_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dcc_rtpb_pkg::cmd_t cmd,
    output dcc_rtpb_pkg::stat_t    stat,
    input  wire logic [2:0]        op,
    input  wire logic              is_accessory,
    input  wire logic [10:0]       address,
    input  wire logic signed [6:0] speed_value,
    input  wire logic              speed_given,
    input  wire logic [12:0]       function_bits,
    input  wire logic              functions_given,
    output logic [1:0]             status,
    output logic [1:0]             packet_kind,
    output logic                   two_address_bytes,
    output logic [7:0]             first_address_byte,
    output logic [7:0]             second_address_byte,
    output logic [7:0]             instruction_byte,
    output logic [7:0]             check_byte
);
    localparam int N = dcc_rtpb_pkg::Entries;
    localparam int IW = dcc_rtpb_pkg::IdxW;
    localparam int CW = dcc_rtpb_pkg::CntW;

    logic [N-1:0]       valid_reg;
    logic [11:0]        key_mem [N];
    logic signed [6:0]  spd_mem [N];
    logic [12:0]        fn_mem  [N];

    logic [2:0]         op_reg;
    logic [11:0]        key_reg;
    logic signed [6:0]  spd_reg;
    logic               sg_reg, fg_reg;
    logic [12:0]        fb_reg;
    logic [IW-1:0]      ptr_reg;
    logic [1:0]         phase_reg;
    logic [IW-1:0]      idx_reg;
    logic [CW-1:0]      cnt_reg;
    logic               hit_reg, room_ok_reg, found_reg;
    logic [IW-1:0]      hit_idx_reg, room_idx_reg;
    logic [1:0]         status_reg, kind_reg;
    logic               two_reg;
    logic [7:0]         a0_reg, a1_reg, ins_reg;

    logic [IW-1:0] cur;
    logic          match;
    logic [IW-1:0] nxt;
    logic          loco_hold;

    assign loco_hold = (phase_reg != 2'd0) && valid_reg[ptr_reg];
    assign nxt = (idx_reg == IW'(N - 1)) ? '0 : idx_reg + 1'b1;
    assign cur = idx_reg;
    assign match = valid_reg[cur] && (key_mem[cur] == key_reg);

    always_comb
    begin
        stat.op = op_reg;
        if (op_reg == dcc_rtpb_pkg::OP_NEXT)
        begin
            stat.scan_done = cmd.scan_first ? loco_hold
                : (found_reg || valid_reg[nxt] || cnt_reg == CW'(N - 1));
        end
        else if (op_reg == dcc_rtpb_pkg::OP_CLEAR_ONE || op_reg == dcc_rtpb_pkg::OP_UPDATE)
        begin
            stat.scan_done = !cmd.scan_first && (hit_reg || cnt_reg == CW'(N));
        end
        else
        begin
            stat.scan_done = 1'b1;
        end
    end

    logic [11:0] ek;
    logic [10:0] ad;
    logic [8:0]  ap;
    logic [7:0]  ins_a, ins_l, a0_l;
    logic [IW-1:0] tgt;
    always_comb
    begin
        ek = key_mem[ptr_reg];
        ad = 11'(ek - 12'd256);
        ap = 9'((ad >> 2) + 11'd1);
        ins_a = {1'b1, ~ap[8:6], spd_mem[ptr_reg] != 7'sd0, ad[1:0], fn_mem[ptr_reg][0]};
        ins_l = (phase_reg == 2'd0) ? dcc_rtpb_pkg::speed_byte(spd_mem[ptr_reg])
            : dcc_rtpb_pkg::function_byte(fn_mem[ptr_reg], phase_reg);
        a0_l = (ek >= 12'h064) ? ({4'd0, ek[11:8]} | 8'hC0) : 8'h00;
        tgt = hit_reg ? hit_idx_reg : room_idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.code == dcc_rtpb_pkg::CMD_APPLY && op_reg == dcc_rtpb_pkg::OP_UPDATE
            && (hit_reg || room_ok_reg))
        begin
            if (!hit_reg)
            begin
                key_mem[tgt] <= key_reg;
            end
            if (sg_reg && spd_reg <= 7'sd32)
            begin
                spd_mem[tgt] <= spd_reg;
            end
            else if (!hit_reg)
            begin
                spd_mem[tgt] <= '0;
            end
            if (fg_reg)
            begin
                fn_mem[tgt] <= fb_reg;
            end
            else if (!hit_reg)
            begin
                fn_mem[tgt] <= 13'd1;
            end
        end
        if (cmd.code == dcc_rtpb_pkg::CMD_SCAN && op_reg == dcc_rtpb_pkg::OP_STOP_ALL)
        begin
            for (int i = 0; i < N; i++)
            begin
                spd_mem[i] <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg <= '0;
            phase_reg <= '0;
            op_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
            hit_reg <= 1'b0;
            room_ok_reg <= 1'b0;
            found_reg <= 1'b0;
            status_reg <= '0;
            kind_reg <= '0;
            two_reg <= 1'b0;
            a0_reg <= '0;
            a1_reg <= '0;
            ins_reg <= '0;
            key_reg <= '0;
            spd_reg <= '0;
            sg_reg <= 1'b0;
            fg_reg <= 1'b0;
            fb_reg <= '0;
            hit_idx_reg <= '0;
            room_idx_reg <= '0;
        end
        else
        begin
            unique case (cmd.code)
                dcc_rtpb_pkg::CMD_LOAD:
                begin
                    op_reg <= op;
                    key_reg <= {1'b0, address} + (is_accessory ? 12'd256 : 12'd0);
                    spd_reg <= speed_value;
                    sg_reg <= speed_given;
                    fg_reg <= functions_given;
                    fb_reg <= function_bits;
                    idx_reg <= (op == dcc_rtpb_pkg::OP_NEXT) ? ptr_reg : '0;
                    cnt_reg <= '0;
                    hit_reg <= 1'b0;
                    room_ok_reg <= 1'b0;
                    found_reg <= 1'b0;
                    status_reg <= dcc_rtpb_pkg::ST_DONE;
                    kind_reg <= dcc_rtpb_pkg::KIND_IDLE;
                    two_reg <= 1'b0;
                    a0_reg <= '0;
                    a1_reg <= '0;
                    ins_reg <= '0;
                end
                dcc_rtpb_pkg::CMD_SCAN:
                begin
                    if (op_reg == dcc_rtpb_pkg::OP_CLEAR_ALL)
                    begin
                        valid_reg <= '0;
                    end
                    else if (op_reg == dcc_rtpb_pkg::OP_NEXT)
                    begin
                        if (cmd.scan_first)
                        begin
                            if (!loco_hold)
                            begin
                                idx_reg <= ptr_reg;
                            end
                        end
                        else if (!stat.scan_done || !found_reg)
                        begin
                            idx_reg <= nxt;
                            cnt_reg <= cnt_reg + 1'b1;
                            found_reg <= valid_reg[nxt];
                        end
                        if (stat.scan_done)
                        begin
                            ptr_reg <= cmd.scan_first ? ptr_reg : nxt;
                        end
                    end
                    else if (!cmd.scan_first && !hit_reg && cnt_reg != CW'(N))
                    begin
                        if (match)
                        begin
                            hit_reg <= 1'b1;
                            hit_idx_reg <= cur;
                        end
                        else
                        begin
                            if (!valid_reg[cur] && !room_ok_reg)
                            begin
                                room_ok_reg <= 1'b1;
                                room_idx_reg <= cur;
                            end
                            idx_reg <= nxt;
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                dcc_rtpb_pkg::CMD_APPLY:
                begin
                    if (op_reg == dcc_rtpb_pkg::OP_CLEAR_ONE && hit_reg)
                    begin
                        valid_reg[hit_idx_reg] <= 1'b0;
                    end
                    else if (op_reg == dcc_rtpb_pkg::OP_UPDATE)
                    begin
                        if (hit_reg || room_ok_reg)
                        begin
                            valid_reg[tgt] <= 1'b1;
                        end
                        else
                        begin
                            status_reg <= dcc_rtpb_pkg::ST_FULL;
                        end
                    end
                end
                dcc_rtpb_pkg::CMD_BUILD:
                begin
                    status_reg <= dcc_rtpb_pkg::ST_PKT;
                    if (!valid_reg[ptr_reg])
                    begin
                        kind_reg <= dcc_rtpb_pkg::KIND_IDLE;
                        a1_reg <= 8'hFF;
                    end
                    else if (ek >= 12'd256)
                    begin
                        kind_reg <= dcc_rtpb_pkg::KIND_ACC;
                        a1_reg <= {2'b10, ap[5:0]};
                        ins_reg <= ins_a;
                        phase_reg <= '0;
                    end
                    else
                    begin
                        kind_reg <= dcc_rtpb_pkg::KIND_LOCO;
                        a1_reg <= ek[7:0];
                        a0_reg <= a0_l;
                        two_reg <= (ek >= 12'h064);
                        ins_reg <= ins_l;
                        phase_reg <= (phase_reg == 2'd3) ? 2'd0 : phase_reg + 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status = status_reg;
    assign packet_kind = kind_reg;
    assign two_address_bytes = two_reg;
    assign first_address_byte = a0_reg;
    assign second_address_byte = a1_reg;
    assign instruction_byte = ins_reg;
    assign check_byte = a0_reg ^ a1_reg ^ ins_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/dcc_refresh_table_packet_builder_core.sv
// Top level of the DCC refresh packet builder: controller plus datapath.
// Depends on dcc_rtpb_pkg, dcc_rtpb_ctrl, dcc_rtpb_dp.
`default_nettype none
// One item at a time. Clear all and stop all go from load through scan and apply to the
// result; clear entry and add/update walk the 16-entry table one entry per cycle until a
// match or until the whole table is walked; next packet steps the round-robin search one
// entry per cycle. The result holds on the output until it is taken.
module dcc_refresh_table_packet_builder_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        op,
    input  wire logic              is_accessory,
    input  wire logic [10:0]       address,
    input  wire logic signed [6:0] speed_value,
    input  wire logic              speed_given,
    input  wire logic [12:0]       function_bits,
    input  wire logic              functions_given,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             status,
    output logic [1:0]             packet_kind,
    output logic                   two_address_bytes,
    output logic [7:0]             first_address_byte,
    output logic [7:0]             second_address_byte,
    output logic [7:0]             instruction_byte,
    output logic [7:0]             check_byte
);
    dcc_rtpb_pkg::cmd_t  cmd;
    dcc_rtpb_pkg::stat_t stat;

    dcc_rtpb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
    );

    dcc_rtpb_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .op(op), .is_accessory(is_accessory), .address(address),
        .speed_value(speed_value), .speed_given(speed_given),
        .function_bits(function_bits), .functions_given(functions_given),
        .status(status), .packet_kind(packet_kind),
        .two_address_bytes(two_address_bytes), .first_address_byte(first_address_byte),
        .second_address_byte(second_address_byte), .instruction_byte(instruction_byte),
        .check_byte(check_byte)
    );

    a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input and output open together");
    a_chk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> check_byte == (first_address_byte ^ second_address_byte ^ instruction_byte))
        else $error("check byte mismatch");
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != dcc_rtpb_pkg::ST_PKT) |-> packet_kind == dcc_rtpb_pkg::KIND_IDLE)
        else $error("kind set on table op");
endmodule
`default_nettype wire
